/* design/frr_pkg.sv */
`default_nettype none
// ============================================================================
// frr_pkg - shared types and constants for the Fresnel reflect/refract block
// Fixed-point formats, case codes, pipeline depths and the item passed from
// the classify front end to the evaluation back end.
// ============================================================================
package frr_pkg;

    localparam int FRAC_BITS   = 14;
    localparam int IN_W        = 16;
    localparam int ETA_W       = 15;
    localparam int COEF_W      = 16;
    localparam int VEC_W       = 18;
    localparam int CASE_W      = 2;
    localparam int DOT_W       = 2 * IN_W + 2;
    localparam int Q30_W       = 31;

    localparam int S_TDATA_W   = 112;
    localparam int M_TDATA_W   = 144;

    localparam int SQRT_LAT    = 32;
    localparam int DIV_LAT     = 31;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // shift amounts between the product scales and the internal formats
    localparam int CSHIFT  = 30 - 2 * FRAC_BITS;
    localparam int ED30_SH = 2 * FRAC_BITS - 18;
    localparam int ED16_SH = 2 * FRAC_BITS - 4;
    localparam int MIR_SH  = 2 * FRAC_BITS - 1;

    localparam logic [63:0] ONE30    = 64'd1 << 30;
    localparam logic [63:0] ONE32    = 64'd1 << 32;
    localparam logic [63:0] ONE60    = 64'd1 << 60;
    localparam logic [63:0] ETA_ONE  = 64'd4096;
    localparam logic [15:0] COEF_ONE = 16'd32768;
    localparam logic [15:0] TOL_RESET = 16'd168;

    localparam logic [CASE_W-1:0] CASE_GENERAL = 2'd0;
    localparam logic [CASE_W-1:0] CASE_NORMAL  = 2'd1;
    localparam logic [CASE_W-1:0] CASE_GRAZING = 2'd2;
    localparam logic [CASE_W-1:0] CASE_TIR     = 2'd3;

    // classified item, front end to back end
    typedef struct packed {
        logic [2:0][IN_W-1:0] iv;
        logic [2:0][IN_W-1:0] nv;
        logic [ETA_W-1:0]     eta;
        logic [DOT_W-1:0]     dot;
        logic [Q30_W-1:0]     c;
        logic [Q30_W-1:0]     s;
        logic [CASE_W-1:0]    kase;
    } fb_t;

    // clamp to the signed 18-bit vector range
    function automatic logic [VEC_W-1:0] sat18(input logic signed [63:0] v);
        logic [VEC_W-1:0] r;
        if (v > 64'sd131071) begin
            r = 18'h1FFFF;
        end else if (v < -64'sd131072) begin
            r = 18'h20000;
        end else begin
            r = v[VEC_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* design/frr_sqrt.sv */
`default_nettype none
// ============================================================================
// frr_sqrt - pipelined integer square root
// floor(sqrt(rad)) of a 64-bit radicand, one restoring step per stage.
// ============================================================================
module frr_sqrt
    import frr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [63:0] rad,
    output logic      [31:0] root
);

    logic [63:0] v_reg [0:SQRT_LAT-1];
    logic [63:0] r_reg [0:SQRT_LAT-1];

    genvar k;
    generate
        for (k = 0; k < SQRT_LAT; k++) begin : g_step
            logic [63:0] v_in, r_in, v_next, r_next, trial;
            localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);

            if (k == 0) begin : g_first
                assign v_in = rad;
                assign r_in = '0;
            end else begin : g_rest
                assign v_in = v_reg[k-1];
                assign r_in = r_reg[k-1];
            end

            always_comb begin
                trial = r_in + BIT;
                if (v_in >= trial) begin
                    v_next = v_in - trial;
                    r_next = (r_in >> 1) + BIT;
                end else begin
                    v_next = v_in;
                    r_next = r_in >> 1;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    v_reg[k] <= v_next;
                    r_reg[k] <= r_next;
                end
            end
        end
    endgenerate

    assign root = r_reg[SQRT_LAT-1][31:0];

endmodule
`default_nettype wire

/* design/frr_div.sv */
`default_nettype none
// ============================================================================
// frr_div - pipelined fraction divider
// floor(num * 2^30 / den) for num <= den, one quotient bit per stage.
// ============================================================================
module frr_div
    import frr_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire logic [63:0]      num,
    input  wire logic [63:0]      den,
    output logic      [Q30_W-1:0] quo
);

    logic [63:0]      r_reg [0:DIV_LAT-1];
    logic [63:0]      d_reg [0:DIV_LAT-1];
    logic [Q30_W-1:0] q_reg [0:DIV_LAT-1];

    genvar k;
    generate
        for (k = 0; k < DIV_LAT; k++) begin : g_step
            logic [63:0]      r_in, d_in, r_next;
            logic [Q30_W-1:0] q_in, q_next;

            if (k == 0) begin : g_first
                assign r_in = num;
                assign d_in = den;
                assign q_in = '0;
            end else begin : g_rest
                assign r_in = r_reg[k-1] << 1;
                assign d_in = d_reg[k-1];
                assign q_in = q_reg[k-1] << 1;
            end

            always_comb begin
                if (r_in >= d_in) begin
                    r_next = r_in - d_in;
                    q_next = q_in | Q30_W'(1);
                end else begin
                    r_next = r_in;
                    q_next = q_in;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    r_reg[k] <= r_next;
                    d_reg[k] <= d_in;
                    q_reg[k] <= q_next;
                end
            end
        end
    endgenerate

    assign quo = q_reg[DIV_LAT-1];

endmodule
`default_nettype wire

/* design/frr_front.sv */
`default_nettype none
// ============================================================================
// frr_front - accept and classify
// Dot product, cosine, sine and the normal / grazing / general decision.
// ============================================================================
module frr_front
    import frr_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [15:0]          guard_tol,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      push,
    output fb_t                       push_item,
    input  wire logic                 q_full
);

    typedef struct packed {
        logic                   valid;
        logic [2:0][IN_W-1:0]   iv;
        logic [2:0][IN_W-1:0]   nv;
        logic [ETA_W-1:0]       eta;
        logic [2:0][2*IN_W-1:0] prod;
        logic [DOT_W-1:0]       dot;
        logic [Q30_W-1:0]       c;
        logic [63:0]            rad;
    } fr_t;

    fr_t f0_reg, f1_reg, f2_reg, f3_reg;
    fr_t f0_next, f1_next, f2_next, f3_next;
    fr_t fd_reg [0:SQRT_LAT-1];
    fb_t f4_reg, f4_next;
    logic f4_valid_reg;
    logic en;
    logic [31:0] root;
    logic [21:0] tol30;

    assign en        = !(f4_valid_reg && q_full);
    assign s_tready  = en;
    assign push      = f4_valid_reg && !q_full;
    assign push_item = f4_reg;
    assign tol30     = {guard_tol, 6'b0};

    always_comb begin
        f0_next       = '0;
        f0_next.valid = s_tvalid;
        for (int j = 0; j < 3; j++) begin
            f0_next.iv[j] = s_tdata[IN_W*j +: IN_W];
            f0_next.nv[j] = s_tdata[3*IN_W + IN_W*j +: IN_W];
        end
        f0_next.eta = s_tdata[6*IN_W +: ETA_W];
    end

    always_comb begin
        f1_next = f0_reg;
        for (int j = 0; j < 3; j++) begin
            f1_next.prod[j] = $signed(f0_reg.iv[j]) * $signed(f0_reg.nv[j]);
        end
    end

    always_comb begin
        logic signed [63:0] d64;
        logic [63:0] absd, cw;
        f2_next = f1_reg;
        d64 = 64'($signed(f1_reg.prod[0])) + 64'($signed(f1_reg.prod[1]))
            + 64'($signed(f1_reg.prod[2]));
        f2_next.dot = d64[DOT_W-1:0];
        absd = (d64 < 0) ? 64'(-d64) : 64'(d64);
        if (CSHIFT >= 0) begin
            cw = absd << CSHIFT;
        end else begin
            cw = absd >> (-CSHIFT);
        end
        f2_next.c = (cw > ONE30) ? ONE30[Q30_W-1:0] : cw[Q30_W-1:0];
    end

    always_comb begin
        f3_next     = f2_reg;
        f3_next.rad = ONE60 - 64'(f2_reg.c) * 64'(f2_reg.c);
    end

    // sine comes out of the root pipe aligned with the last delay tap
    always_comb begin
        f4_next.iv  = fd_reg[SQRT_LAT-1].iv;
        f4_next.nv  = fd_reg[SQRT_LAT-1].nv;
        f4_next.eta = fd_reg[SQRT_LAT-1].eta;
        f4_next.dot = fd_reg[SQRT_LAT-1].dot;
        f4_next.c   = fd_reg[SQRT_LAT-1].c;
        f4_next.s   = root[Q30_W-1:0];
        if (root[Q30_W-1:0] <= Q30_W'(tol30)) begin
            f4_next.kase = CASE_NORMAL;
        end else if (fd_reg[SQRT_LAT-1].c <= Q30_W'(tol30)) begin
            f4_next.kase = CASE_GRAZING;
        end else begin
            f4_next.kase = CASE_GENERAL;
        end
    end

    frr_sqrt u_sqrt (
        .aclk (aclk),
        .en   (en),
        .rad  (f3_reg.rad),
        .root (root)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f0_reg       <= '0;
            f1_reg       <= '0;
            f2_reg       <= '0;
            f3_reg       <= '0;
            for (int k = 0; k < SQRT_LAT; k++) begin
                fd_reg[k] <= '0;
            end
            f4_reg       <= '0;
            f4_valid_reg <= 1'b0;
        end else if (en) begin
            f0_reg    <= f0_next;
            f1_reg    <= f1_next;
            f2_reg    <= f2_next;
            f3_reg    <= f3_next;
            fd_reg[0] <= f3_reg;
            for (int k = 1; k < SQRT_LAT; k++) begin
                fd_reg[k] <= fd_reg[k-1];
            end
            f4_reg       <= f4_next;
            f4_valid_reg <= fd_reg[SQRT_LAT-1].valid;
        end
    end

endmodule
`default_nettype wire

/* design/frr_queue.sv */
`default_nettype none
// ============================================================================
// frr_queue - short item queue between front end and back end
// Lets either side stall without holding up the other.
// ============================================================================
module frr_queue
    import frr_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire fb_t  wr_item,
    output logic      full,
    input  wire logic pop,
    output fb_t       rd_item,
    output logic      empty
);

    fb_t              mem [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;

    assign full    = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_item = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= QPTR_W'(wr_ptr_reg + 1'b1);
            end
            if (pop) begin
                rd_ptr_reg <= QPTR_W'(rd_ptr_reg + 1'b1);
            end
            if (push && !pop) begin
                cnt_reg <= QCNT_W'(cnt_reg + 1'b1);
            end else if (pop && !push) begin
                cnt_reg <= QCNT_W'(cnt_reg - 1'b1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full)) else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty)) else $error("queue read while empty");

    a_count_tracks_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == QCNT_W'(QUEUE_DEPTH))
        || (cnt_reg == QCNT_W'(QPTR_W'(wr_ptr_reg - rd_ptr_reg))))
        else $error("queue count disagrees with pointers");

endmodule
`default_nettype wire

/* design/frr_back.sv */
`default_nettype none
// ============================================================================
// frr_back - evaluate coefficients and vectors
// Refraction sine/cosine, Fresnel ratios, mirror and bent vectors, and a
// two-entry output buffer.
// ============================================================================
module frr_back
    import frr_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 q_empty,
    input  wire fb_t                  q_item,
    output logic                      pop,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic [CASE_W-1:0]         m_tuser
);

    localparam int OB_DEPTH = 2;
    localparam int OB_W     = M_TDATA_W + CASE_W;

    typedef struct packed {
        logic                  valid;
        logic [CASE_W-1:0]     kase;
        logic                  tir;
        logic                  use_k;
        logic                  bend_ok;
        logic [2:0][IN_W-1:0]  iv;
        logic [2:0][IN_W-1:0]  nv;
        logic [ETA_W-1:0]      eta;
        logic [DOT_W-1:0]      dot;
        logic [Q30_W-1:0]      c;
        logic [Q30_W-1:0]      s;
        logic [33:0]           st;
        logic [49:0]           ed_prod;
        logic [2:0][49:0]      mprod;
        logic [2:0][31:0]      eiv;
        logic [31:0]           d2;
        logic [31:0]           p2;
        logic [39:0]           ed30;
        logic [25:0]           ed16;
        logic [59:0]           st2;
        logic [29:0]           eta2;
        logic [51:0]           ed16sq;
        logic [2:0][VEC_W-1:0] mir;
        logic [63:0]           rad;
        logic [43:0]           m;
        logic [61:0]           a;
        logic [61:0]           b;
        logic [61:0]           cc;
        logic [61:0]           ee;
        logic [63:0]           num1;
        logic [63:0]           den1;
        logic [63:0]           num2;
        logic [63:0]           den2;
        logic [2:0][59:0]      nvm;
        logic [Q30_W-1:0]      q1;
        logic [Q30_W-1:0]      rs;
        logic [Q30_W-1:0]      q2s;
        logic [Q30_W-1:0]      rp;
        logic [2:0][VEC_W-1:0] bent;
    } bk_t;

    bk_t b0_reg, b1_reg, b2_reg, b3_reg, b4_reg, b5_reg, b6_reg, b7_reg, b8_reg;
    bk_t b0_next, b1_next, b2_next, b3_next, b4_next, b5_next, b6_next, b7_next;
    bk_t sd_reg [0:SQRT_LAT-1];
    bk_t dd_reg [0:DIV_LAT-1];

    logic             en;
    logic [31:0]      root;
    logic [Q30_W-1:0] q1, q2;

    logic [OB_W-1:0]  ob_mem [0:OB_DEPTH-1];
    logic             ob_wr_reg, ob_rd_reg;
    logic [1:0]       ob_cnt_reg;
    logic             ob_push, ob_pop;
    logic [OB_W-1:0]  ob_in;

    assign en  = !(b8_reg.valid && (ob_cnt_reg == 2'(OB_DEPTH)));
    assign pop = en && !q_empty;

    always_comb begin
        b0_next       = '0;
        b0_next.valid = !q_empty;
        b0_next.kase  = q_item.kase;
        b0_next.iv    = q_item.iv;
        b0_next.nv    = q_item.nv;
        b0_next.eta   = q_item.eta;
        b0_next.dot   = q_item.dot;
        b0_next.c     = q_item.c;
        b0_next.s     = q_item.s;
    end

    // products of the inputs
    always_comb begin
        logic signed [63:0] t, dd, pp;
        b1_next    = b0_reg;
        t          = 64'(b0_reg.s) * 64'(b0_reg.eta);
        b1_next.st = t[45:12];
        t          = $signed(b0_reg.dot) * $signed({1'b0, b0_reg.eta});
        b1_next.ed_prod = t[49:0];
        for (int j = 0; j < 3; j++) begin
            t = $signed(b0_reg.dot) * $signed(b0_reg.nv[j]);
            b1_next.mprod[j] = t[49:0];
            t = $signed(b0_reg.iv[j]) * $signed({1'b0, b0_reg.eta});
            b1_next.eiv[j] = t[31:0];
        end
        dd = $signed(64'(b0_reg.eta)) - $signed(ETA_ONE);
        pp = $signed(64'(b0_reg.eta)) + $signed(ETA_ONE);
        t  = dd * dd;
        b1_next.d2 = t[31:0];
        t  = pp * pp;
        b1_next.p2 = t[31:0];
    end

    // scaled eta*dot, squares, mirror vector
    always_comb begin
        logic signed [63:0] ep, sh, t, ms, dv;
        logic [63:0] u;
        b2_next      = b1_reg;
        ep           = 64'($signed(b1_reg.ed_prod));
        sh           = ep >>> ED30_SH;
        b2_next.ed30 = sh[39:0];
        sh           = ep >>> ED16_SH;
        b2_next.ed16 = sh[25:0];
        b2_next.tir  = (64'(b1_reg.st) >= ONE30);
        u            = 64'(b1_reg.st[29:0]) * 64'(b1_reg.st[29:0]);
        b2_next.st2  = u[59:0];
        u            = 64'(b1_reg.eta) * 64'(b1_reg.eta);
        b2_next.eta2 = u[29:0];
        t            = $signed(sh[25:0]) * $signed(sh[25:0]);
        b2_next.ed16sq = t[51:0];
        for (int j = 0; j < 3; j++) begin
            ms = 64'($signed(b1_reg.mprod[j])) >>> MIR_SH;
            dv = 64'($signed(b1_reg.iv[j])) - ms;
            b2_next.mir[j] = sat18(dv);
        end
    end

    // case resolve and root radicand
    always_comb begin
        logic signed [63:0] k32;
        b3_next = b2_reg;
        k32 = $signed(ONE32) - $signed(64'(b2_reg.eta2) << 8)
            + $signed(64'(b2_reg.ed16sq));
        b3_next.use_k = (b2_reg.kase == CASE_NORMAL) || (b2_reg.kase == CASE_GRAZING);
        if (b3_next.use_k) begin
            b3_next.bend_ok = (k32 >= 0);
            b3_next.rad     = (k32 < 0) ? 64'd0 : 64'(k32);
        end else begin
            b3_next.bend_ok = !b2_reg.tir;
            b3_next.rad     = b2_reg.tir ? 64'd0 : ONE60 - 64'(b2_reg.st2);
            if (b2_reg.tir) begin
                b3_next.kase = CASE_TIR;
            end
        end
    end

    frr_sqrt u_sqrt (
        .aclk (aclk),
        .en   (en),
        .rad  (b3_reg.rad),
        .root (root)
    );

    // refraction cosine, angle products
    always_comb begin
        logic [39:0] root30;
        logic [63:0] ct, st30, u;
        logic signed [63:0] mm;
        b4_next = sd_reg[SQRT_LAT-1];
        root30  = sd_reg[SQRT_LAT-1].use_k ? (40'(root) << 14) : 40'(root);
        ct      = 64'(root[Q30_W-1:0]);
        st30    = 64'(sd_reg[SQRT_LAT-1].st[29:0]);
        mm      = 64'($signed(sd_reg[SQRT_LAT-1].ed30)) + $signed(64'(root30));
        b4_next.m  = mm[43:0];
        u          = 64'(sd_reg[SQRT_LAT-1].s) * ct;
        b4_next.a  = u[61:0];
        u          = st30 * 64'(sd_reg[SQRT_LAT-1].c);
        b4_next.b  = u[61:0];
        u          = 64'(sd_reg[SQRT_LAT-1].c) * ct;
        b4_next.cc = u[61:0];
        u          = 64'(sd_reg[SQRT_LAT-1].s) * st30;
        b4_next.ee = u[61:0];
    end

    // divider operands, normal-incidence ratio shares the first divider
    always_comb begin
        logic signed [63:0] t;
        b5_next = b4_reg;
        if (b4_reg.kase == CASE_NORMAL) begin
            b5_next.num1 = 64'(b4_reg.d2);
            b5_next.den1 = 64'(b4_reg.p2);
        end else begin
            b5_next.num1 = (b4_reg.a > b4_reg.b) ? 64'(b4_reg.a - b4_reg.b)
                                                 : 64'(b4_reg.b - b4_reg.a);
            b5_next.den1 = 64'(b4_reg.a) + 64'(b4_reg.b);
        end
        b5_next.num2 = (b4_reg.cc > b4_reg.ee) ? 64'(b4_reg.cc - b4_reg.ee)
                                               : 64'(b4_reg.ee - b4_reg.cc);
        b5_next.den2 = 64'(b4_reg.cc) + 64'(b4_reg.ee);
        for (int j = 0; j < 3; j++) begin
            t = $signed(b4_reg.nv[j]) * $signed(b4_reg.m);
            b5_next.nvm[j] = t[59:0];
        end
    end

    frr_div u_div1 (
        .aclk (aclk),
        .en   (en),
        .num  (b5_reg.num1),
        .den  (b5_reg.den1),
        .quo  (q1)
    );

    frr_div u_div2 (
        .aclk (aclk),
        .en   (en),
        .num  (b5_reg.num2),
        .den  (b5_reg.den2),
        .quo  (q2)
    );

    // squared ratios, bent vector
    always_comb begin
        logic [63:0] u;
        logic signed [63:0] ev, dv;
        b6_next     = dd_reg[DIV_LAT-1];
        b6_next.q1  = q1;
        u           = 64'(q1) * 64'(q1);
        b6_next.rs  = u[60:30];
        u           = 64'(q2) * 64'(q2);
        b6_next.q2s = u[60:30];
        for (int j = 0; j < 3; j++) begin
            ev = 64'($signed(dd_reg[DIV_LAT-1].eiv[j])) <<< 18;
            dv = (ev - 64'($signed(dd_reg[DIV_LAT-1].nvm[j]))) >>> 30;
            b6_next.bent[j] = dd_reg[DIV_LAT-1].bend_ok ? sat18(dv) : '0;
        end
    end

    always_comb begin
        logic [63:0] u;
        b7_next    = b6_reg;
        u          = 64'(b6_reg.rs) * 64'(b6_reg.q2s);
        b7_next.rp = u[60:30];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b0_reg <= '0;
            b1_reg <= '0;
            b2_reg <= '0;
            b3_reg <= '0;
            b4_reg <= '0;
            b5_reg <= '0;
            b6_reg <= '0;
            b7_reg <= '0;
            b8_reg <= '0;
            for (int k = 0; k < SQRT_LAT; k++) begin
                sd_reg[k] <= '0;
            end
            for (int k = 0; k < DIV_LAT; k++) begin
                dd_reg[k] <= '0;
            end
        end else if (en) begin
            b0_reg    <= b0_next;
            b1_reg    <= b1_next;
            b2_reg    <= b2_next;
            b3_reg    <= b3_next;
            sd_reg[0] <= b3_reg;
            for (int k = 1; k < SQRT_LAT; k++) begin
                sd_reg[k] <= sd_reg[k-1];
            end
            b4_reg    <= b4_next;
            b5_reg    <= b5_next;
            dd_reg[0] <= b5_reg;
            for (int k = 1; k < DIV_LAT; k++) begin
                dd_reg[k] <= dd_reg[k-1];
            end
            b6_reg <= b6_next;
            b7_reg <= b7_next;
            b8_reg <= b7_reg;
        end
    end

    // result assembly
    always_comb begin
        logic [31:0] sum;
        logic [COEF_W-1:0] kr, kt;
        sum = 32'(b8_reg.rs) + 32'(b8_reg.rp);
        unique case (b8_reg.kase)
            CASE_NORMAL:  kr = b8_reg.q1[30:15];
            CASE_GENERAL: kr = sum[31:16];
            default:      kr = COEF_ONE;
        endcase
        kt    = COEF_ONE - kr;
        ob_in = {b8_reg.kase, 4'b0,
                 b8_reg.bent[2], b8_reg.bent[1], b8_reg.bent[0],
                 b8_reg.mir[2], b8_reg.mir[1], b8_reg.mir[0], kt, kr};
    end

    assign ob_push  = b8_reg.valid && en;
    assign ob_pop   = m_tvalid && m_tready;
    assign m_tvalid = (ob_cnt_reg != 2'd0);
    assign m_tdata  = ob_mem[ob_rd_reg][M_TDATA_W-1:0];
    assign m_tuser  = ob_mem[ob_rd_reg][OB_W-1:M_TDATA_W];

    always_ff @(posedge aclk) begin
        if (ob_push) begin
            ob_mem[ob_wr_reg] <= ob_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ob_wr_reg  <= 1'b0;
            ob_rd_reg  <= 1'b0;
            ob_cnt_reg <= 2'd0;
        end else begin
            if (ob_push) begin
                ob_wr_reg <= !ob_wr_reg;
            end
            if (ob_pop) begin
                ob_rd_reg <= !ob_rd_reg;
            end
            if (ob_push && !ob_pop) begin
                ob_cnt_reg <= ob_cnt_reg + 2'd1;
            end else if (ob_pop && !ob_push) begin
                ob_cnt_reg <= ob_cnt_reg - 2'd1;
            end
        end
    end

    a_ob_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ob_cnt_reg <= 2'(OB_DEPTH)) else $error("output buffer overrun");

endmodule
`default_nettype wire

/* design/fresnel_reflect_refract.sv */
`default_nettype none
// ============================================================================
// fresnel_reflect_refract - unpolarized Fresnel reflectance with vectors
// Top level: config register, classify front end, queue, evaluation back end.
// ============================================================================
// Takes one item per clock while s_tready is high; one result per item, in
// order. Each input carries an incident vector and a surface normal (signed
// Q1.14) and an index ratio eta (unsigned Q3.12); the result is the
// reflectance kr and kt = 1 - kr (Q1.15), the mirror vector and the refracted
// vector (signed Q3.14, saturated, refracted vector zero on total internal
// reflection), and a case code in m_tuser: general, normal incidence,
// grazing incidence or total internal reflection. Sustained rate is one item
// per cycle while s_tready is high. The front end holds a 32-stage square
// root for the sine; the queue follows it, and the back end holds a second
// 32-stage square root for the refraction cosine followed by two 31-stage
// fraction dividers and then the output buffer. A four-item queue between
// front and back and a two-item output buffer let s_tready stay high while a
// result waits on m_tready, until both have filled.
// guard_tolerance (reset 168, units of 2^-24) sets the near-zero thresholds;
// write it through cfg_we/cfg_wdata only while no item is in flight.
module fresnel_reflect_refract
    import frr_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // guard_tolerance write port
    input  wire logic                 cfg_we,
    input  wire logic [15:0]          cfg_wdata,
    // input items
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // incident_x, incident_y, incident_z, normal_x, normal_y, normal_z,
    // index_ratio, zero pad
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // result items
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // reflect_coeff, transmit_coeff, mirror_x, mirror_y, mirror_z,
    // bent_x, bent_y, bent_z, zero pad
    output logic [M_TDATA_W-1:0]      m_tdata,
    // incidence_case
    output logic [CASE_W-1:0]         m_tuser
);

    logic [15:0] tol_reg;
    logic        q_push, q_pop, q_full, q_empty;
    fb_t         q_wr_item, q_rd_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= TOL_RESET;
        end else if (cfg_we) begin
            tol_reg <= cfg_wdata;
        end
    end

    // dot product, sine/cosine, guard classification
    frr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .guard_tol (tol_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .push      (q_push),
        .push_item (q_wr_item),
        .q_full    (q_full)
    );

    frr_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_item (q_wr_item),
        .full    (q_full),
        .pop     (q_pop),
        .rd_item (q_rd_item),
        .empty   (q_empty)
    );

    // coefficients, vectors, output buffer
    frr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_item   (q_rd_item),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire

/* sim/fresnel_reflect_refract_tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// fresnel_reflect_refract_tb - self-checking bench for the Fresnel block
// Drives ray items on the s_ stream, predicts kr, kt, the mirror and bent
// vectors and the case code in fixed point, and checks each m_ item in order.
// ============================================================================
module fresnel_reflect_refract_tb;
    import frr_pkg::*;

    // ray item as sent on s_tdata
    typedef struct {
        logic signed [IN_W-1:0] iv[3];
        logic signed [IN_W-1:0] nv[3];
        logic [ETA_W-1:0]       eta;
    } ray_t;

    // result item as expected on m_tdata / m_tuser
    typedef struct {
        logic [COEF_W-1:0] kr;
        logic [COEF_W-1:0] kt;
        logic [VEC_W-1:0]  mir[3];
        logic [VEC_W-1:0]  bent[3];
        logic [CASE_W-1:0] kase;
    } shade_t;

    localparam int HOLD_CYCLES  = 400;   // long receiver stall
    localparam int SETTLE_WAIT  = 160;   // wait after a drain, plus margin
    localparam int STALL_LIMIT  = 20000; // cycles with no item accepted

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [15:0]          cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [CASE_W-1:0]    m_tuser;

    shade_t      shade_queue[$];  // predicted results, oldest first
    logic [15:0] tol_now = TOL_RESET;
    int          errors = 0;
    bit          tx_idle = 1'b1;  // sender draws gaps
    bit          rx_idle = 1'b1;  // receiver draws gaps
    bit          hold_req = 1'b0;

    always #5 aclk = ~aclk;

    fresnel_reflect_refract u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // ------------------------------------------------------------------
    // Fixed-point predictor
    // ------------------------------------------------------------------
    function automatic longint unsigned root64(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // floor(num * 2^30 / den), num <= den
    function automatic longint unsigned ratio30(input longint unsigned num,
                                                input longint unsigned den);
        longint unsigned q, r;
        q = 0;
        r = num;
        if (r >= den) begin
            r = r - den;
            q = 1;
        end
        for (int k = 0; k < 30; k++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 1;
            end
        end
        return q;
    endfunction

    function automatic logic [VEC_W-1:0] clamp18(input longint v);
        if (v > 131071) v = 131071;
        if (v < -131072) v = -131072;
        return v[VEC_W-1:0];
    endfunction

    function automatic shade_t fresnel_predict(input ray_t r, input logic [15:0] tol);
        shade_t          o;
        longint          dot, eta, ed30, ed16, k32, root, m, d, p;
        longint unsigned absdot, c, s, tol30, kr, st, ct, a, b, cc, ee, q1, q2, rs, rp;
        bit              use_k, bend_ok;
        dot = 0;
        for (int j = 0; j < 3; j++) dot += longint'(r.iv[j]) * longint'(r.nv[j]);
        eta = longint'({1'b0, r.eta});
        use_k = 0;
        bend_ok = 1;
        root = 0;
        absdot = (dot < 0) ? longint'(-dot) : dot;
        c = absdot << 2;
        if (c > (64'd1 << 30)) c = 64'd1 << 30;
        s = root64((64'd1 << 60) - c * c);
        tol30 = longint'(tol) << 6;
        ed30 = (eta * dot) >>> 10;
        if (s <= tol30) begin
            // normal incidence
            d = eta - 4096;
            p = eta + 4096;
            o.kase = CASE_NORMAL;
            kr = longint'((d * d) << 15) / longint'(p * p);
            use_k = 1;
        end else if (c <= tol30) begin
            o.kase = CASE_GRAZING;
            kr = 32768;
            use_k = 1;
        end else begin
            st = (s * eta) >> 12;
            if (st >= (64'd1 << 30)) begin
                o.kase = CASE_TIR;
                kr = 32768;
                bend_ok = 0;
            end else begin
                o.kase = CASE_GENERAL;
                ct = root64((64'd1 << 60) - st * st);
                a = s * ct;
                b = st * c;
                cc = c * ct;
                ee = s * st;
                q1 = ratio30((a > b) ? a - b : b - a, a + b);
                q2 = ratio30((cc > ee) ? cc - ee : ee - cc, cc + ee);
                rs = (q1 * q1) >> 30;
                rp = (rs * ((q2 * q2) >> 30)) >> 30;
                kr = ((rs + rp) >> 1) >> 15;
                root = ct;
            end
        end
        if (use_k) begin
            ed16 = (eta * dot) >>> 24;
            k32 = (64'sd1 <<< 32) - eta * eta * 256 + ed16 * ed16;
            if (k32 < 0) bend_ok = 0;
            else root = root64(k32) << 14;
        end
        o.kr = kr[15:0];
        o.kt = 16'(64'd32768 - kr);
        m = ed30 + root;
        for (int j = 0; j < 3; j++) begin
            o.mir[j] = clamp18(longint'(r.iv[j]) - ((2 * dot * longint'(r.nv[j])) >>> 28));
            o.bent[j] = bend_ok ? clamp18((eta * longint'(r.iv[j]) * 262144
                                           - longint'(r.nv[j]) * m) >>> 30) : '0;
        end
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Sender: one item, optional gap first; s_tvalid stays high after
    // ------------------------------------------------------------------
    task automatic send_ray(input ray_t r);
        int gap;
        gap = tx_idle ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, r.eta, r.nv[2], r.nv[1], r.nv[0], r.iv[2], r.iv[1], r.iv[0]};
        do @(posedge aclk); while (!s_tready);
        shade_queue.push_back(fresnel_predict(r, tol_now));
    endtask

    // stop sending and wait until every predicted item has come back
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (shade_queue.size() != 0) @(posedge aclk);
    endtask

    // write guard_tolerance with the pipe empty
    task automatic set_tolerance(input logic [15:0] v);
        drain();
        repeat (SETTLE_WAIT) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we  <= 1'b0;
        tol_now = v;
    endtask

    function automatic ray_t mk_ray(input int ix, iy, iz, nx, ny, nz, eta);
        ray_t r;
        r.iv[0] = IN_W'(ix); r.iv[1] = IN_W'(iy); r.iv[2] = IN_W'(iz);
        r.nv[0] = IN_W'(nx); r.nv[1] = IN_W'(ny); r.nv[2] = IN_W'(nz);
        r.eta = ETA_W'(eta);
        return r;
    endfunction

    // component with random magnitude scale
    function automatic logic signed [IN_W-1:0] rnd_comp;
        logic signed [IN_W-1:0] v;
        v = IN_W'($urandom_range(0, 65535));
        return v >>> $urandom_range(0, 3);
    endfunction

    // random ray: mostly physically sensible, some pure noise
    function automatic ray_t rnd_ray;
        ray_t r;
        int   kind, n;
        kind = $urandom_range(0, 9);
        for (int j = 0; j < 3; j++) begin
            r.iv[j] = rnd_comp();
            r.nv[j] = rnd_comp();
        end
        if (kind == 0) begin
            for (int j = 0; j < 3; j++) begin
                r.iv[j] = IN_W'($urandom_range(0, 65535));
                r.nv[j] = IN_W'($urandom_range(0, 65535));
            end
        end else if (kind == 1) begin
            // near-perpendicular: grazing region
            n = $urandom_range(0, 2);
            r.nv[n] = rnd_comp();
            r.nv[(n + 1) % 3] = IN_W'(int'($urandom_range(0, 7)) - 4);
            r.nv[(n + 2) % 3] = IN_W'(int'($urandom_range(0, 7)) - 4);
            r.iv[n] = IN_W'(int'($urandom_range(0, 31)) - 16);
        end else if (kind == 2) begin
            // antiparallel unit vectors: normal incidence
            n = $urandom_range(0, 2);
            for (int j = 0; j < 3; j++) begin
                r.iv[j] = IN_W'(int'($urandom_range(0, 3)) - 2);
                r.nv[j] = '0;
            end
            r.nv[n] = $urandom_range(0, 1) ? IN_W'(16384) : IN_W'(-16384);
            r.iv[n] = IN_W'(-int'(r.nv[n]) + int'($urandom_range(0, 7)) - 4);
        end
        if (kind == 3) r.eta = ETA_W'($urandom_range(0, 32767));
        else r.eta = ETA_W'($urandom_range(2048, 10240));
        return r;
    endfunction

    task automatic run_random(input int count);
        repeat (count) send_ray(rnd_ray());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed;
        send_ray(mk_ray(0, 0, 0, 0, 0, 0, 0));
        send_ray(mk_ray(-32768, -32768, -32768, -32768, -32768, -32768, 32767));
        send_ray(mk_ray(32767, 32767, 32767, 32767, 32767, 32767, 0));
        send_ray(mk_ray(32767, -32768, 32767, -32768, 32767, -32768, 4096));
        // normal incidence, several index ratios
        send_ray(mk_ray(0, 0, -16384, 0, 0, 16384, 4096));
        send_ray(mk_ray(0, 0, -16384, 0, 0, 16384, 6144));
        send_ray(mk_ray(-16384, 0, 0, 16384, 0, 0, 32767));
        send_ray(mk_ray(0, 16384, 0, 0, 16384, 0, 0));
        // grazing: incident in the surface plane
        send_ray(mk_ray(16384, 0, 0, 0, 0, 16384, 4096));
        send_ray(mk_ray(0, 16384, 0, 0, 0, -16384, 2048));
        send_ray(mk_ray(16384, 0, 0, 0, 0, 16384, 32767));  // k < 0
        // total internal reflection at 45 degrees going dense to thin
        send_ray(mk_ray(11585, 0, -11585, 0, 0, 16384, 8192));
        send_ray(mk_ray(11585, 0, -11585, 0, 0, 16384, 32767));
        // general, entering and leaving
        send_ray(mk_ray(11585, 0, -11585, 0, 0, 16384, 3072));
        send_ray(mk_ray(8192, 0, -14189, 0, 0, 16384, 5461));
        send_ray(mk_ray(8192, 8192, -11585, 0, 0, 16384, 4096));
        // oversized vectors for saturation
        send_ray(mk_ray(32767, 32767, -32768, 0, -32768, 32767, 32767));
        send_ray(mk_ray(-32768, 32767, 32767, 32767, 32767, 0, 1));
    endtask

    task automatic test_back_pressure;
        // receiver stops for a long stretch while items keep coming;
        // more items than the pipe holds, so s_tready drops
        tx_idle = 1'b0;
        hold_req = 1'b1;
        run_random(200);
        tx_idle = 1'b1;
        drain();
    endtask

    // ------------------------------------------------------------------
    // Receiver: per-item gap, or a long hold on request
    // ------------------------------------------------------------------
    int hold_cnt = 0;
    int gap_cnt  = 0;
    always @(posedge aclk) begin
        logic rdy;
        rdy = 1'b1;
        if (hold_req) begin
            hold_cnt = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (!aresetn) begin
            rdy = 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            rdy = 1'b0;
        end else if (gap_cnt > 0) begin
            gap_cnt--;
            rdy = (gap_cnt == 0);
        end else if (m_tvalid && m_tready) begin
            gap_cnt = rx_idle ? $urandom_range(0, 6) : 0;
            rdy = (gap_cnt == 0);
        end
        m_tready <= rdy;
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input longint unsigned exp_v,
                               input longint unsigned act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        shade_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (shade_queue.size() == 0) begin
                $display("%0t: unexpected result item, expected none actual %0h",
                         $time, m_tdata);
                errors++;
            end else begin
                e = shade_queue.pop_front();
                check_field("reflect_coeff", 64'(e.kr), 64'(m_tdata[15:0]));
                check_field("transmit_coeff", 64'(e.kt), 64'(m_tdata[31:16]));
                for (int j = 0; j < 3; j++) begin
                    check_field($sformatf("mirror[%0d]", j), 64'(e.mir[j]),
                                64'(m_tdata[32 + 18 * j +: 18]));
                    check_field($sformatf("bent[%0d]", j), 64'(e.bent[j]),
                                64'(m_tdata[86 + 18 * j +: 18]));
                end
                check_field("incidence_case", 64'(e.kase), 64'(m_tuser));
            end
        end
    end

    // watchdog: too long with no item accepted on either side
    int quiet = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
        else quiet++;
        if (quiet >= STALL_LIMIT) begin
            $display("fresnel_reflect_refract: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        run_random(380);            // reset tolerance

        rx_idle = 1'b0;             // stretch with no idling
        tx_idle = 1'b0;
        run_random(200);
        rx_idle = 1'b1;
        tx_idle = 1'b1;

        test_back_pressure();

        set_tolerance(16'd0);
        test_directed();
        run_random(350);

        set_tolerance(16'hFFFF);
        test_directed();
        run_random(300);

        set_tolerance(16'($urandom_range(1, 4000)));
        run_random(300);

        set_tolerance(16'($urandom_range(0, 65535)));
        run_random(200);

        drain();
        repeat (SETTLE_WAIT) @(posedge aclk);
        if (errors == 0) begin
            $display("fresnel_reflect_refract: match");
        end else begin
            $display("fresnel_reflect_refract: mismatch");
        end
        $finish;
    end

endmodule
